// ===== hw/rtl/dfq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfq_pkg: shared types and constants of the delimited field quoter
// Holds the request payload types, the command that passes from the front to
// the back, the scan mode encoding and the character constants.
// ----------------------------------------------------------------------------
package dfq_pkg;

	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChSpace     = 8'h20;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChNewline   = 8'h0A;
	localparam logic [7:0] ChDash      = 8'h2D;
	localparam logic [7:0] DelimReset  = 8'h2C;

	// Command queue depth between the front and the back (two or more).
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		MODE_SCAN  = 2'd0,
		MODE_QTOK  = 2'd1,
		MODE_DELIM = 2'd2,
		MODE_NQTOK = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_req_t;

	// One or two output bytes caused by one input request.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} cmd_t;

endpackage

// ===== hw/rtl/dfq_front.sv =====
// ----------------------------------------------------------------------------
// dfq_front: input acceptance and character classification
// Runs the four-mode scanner, holds the delimiter register and turns each
// input request that yields output into a command of one or two output bytes.
// ----------------------------------------------------------------------------
module dfq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  dfq_pkg::in_req_t  in_data,
	input  logic              q_full,
	output logic              push,
	output dfq_pkg::cmd_t     push_cmd
);

	dfq_pkg::mode_t mode_q;
	dfq_pkg::mode_t mode_next;
	logic [7:0]     delim_q;
	logic           has_out;
	logic           accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && has_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= dfq_pkg::DelimReset;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dfq_pkg::MODE_SCAN;
		end else if (accept) begin
			mode_q <= mode_next;
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       eoi;
		logic       is_q;
		logic       is_nl;
		logic       is_d;
		c         = in_data.in_byte;
		eoi       = in_data.end_of_input;
		is_q      = !eoi && (c == dfq_pkg::ChQuote);
		is_nl     = !eoi && (c == dfq_pkg::ChNewline);
		is_d      = !eoi && (c == delim_q);
		mode_next = mode_q;
		has_out   = 1'b1;
		push_cmd  = '{two: 1'b0, b0: c, b1: c};
		case (mode_q)
			dfq_pkg::MODE_SCAN: begin
				if (eoi) begin
					has_out = 1'b0;
				end else if (is_q) begin
					push_cmd.b0 = dfq_pkg::ChQuote;
					mode_next   = dfq_pkg::MODE_QTOK;
				end else if (c inside {dfq_pkg::ChSpace, dfq_pkg::ChTab,
						dfq_pkg::ChNewline}) begin
					push_cmd.b0 = c;
				end else if (is_d) begin
					push_cmd.b0 = dfq_pkg::ChSpace;
					mode_next   = dfq_pkg::MODE_DELIM;
				end else begin
					push_cmd  = '{two: 1'b1, b0: dfq_pkg::ChQuote, b1: c};
					mode_next = dfq_pkg::MODE_NQTOK;
				end
			end
			dfq_pkg::MODE_QTOK: begin
				if (eoi || is_q) begin
					push_cmd.b0 = dfq_pkg::ChQuote;
					mode_next   = dfq_pkg::MODE_SCAN;
				end
			end
			dfq_pkg::MODE_DELIM: begin
				if (is_q) begin
					push_cmd.b0 = dfq_pkg::ChQuote;
					mode_next   = dfq_pkg::MODE_QTOK;
				end else if (eoi || is_nl) begin
					push_cmd.b0 = dfq_pkg::ChNewline;
					mode_next   = dfq_pkg::MODE_SCAN;
				end else if (is_d) begin
					push_cmd = '{two: 1'b1, b0: dfq_pkg::ChDash, b1: dfq_pkg::ChSpace};
				end else begin
					push_cmd  = '{two: 1'b1, b0: dfq_pkg::ChQuote, b1: c};
					mode_next = dfq_pkg::MODE_NQTOK;
				end
			end
			dfq_pkg::MODE_NQTOK: begin
				if (eoi || is_nl) begin
					push_cmd  = '{two: 1'b1, b0: dfq_pkg::ChQuote, b1: dfq_pkg::ChNewline};
					mode_next = dfq_pkg::MODE_SCAN;
				end else if (is_q) begin
					push_cmd = '{two: 1'b1, b0: dfq_pkg::ChQuote, b1: dfq_pkg::ChQuote};
				end else if (is_d) begin
					push_cmd  = '{two: 1'b1, b0: dfq_pkg::ChQuote, b1: dfq_pkg::ChSpace};
					mode_next = dfq_pkg::MODE_DELIM;
				end
			end
			default: begin
				has_out   = 1'b0;
				mode_next = dfq_pkg::MODE_SCAN;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dfq_queue.sv =====
// ----------------------------------------------------------------------------
// dfq_queue: command queue between front and back
// A small register FIFO of byte commands, so the two sides stall apart.
// ----------------------------------------------------------------------------
module dfq_queue #(
	parameter int Depth = dfq_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfq_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dfq_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	dfq_pkg::cmd_t   entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/dfq_back.sv =====
// ----------------------------------------------------------------------------
// dfq_back: output byte sequencer
// Pops commands and emits their bytes one per cycle while out_stall is low
// through an output register, marking the final byte of each command.
// ----------------------------------------------------------------------------
module dfq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dfq_pkg::cmd_t     q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output dfq_pkg::out_req_t out_data
);

	logic              out_valid_q;
	dfq_pkg::out_req_t out_data_q;
	logic              pend_q;
	logic [7:0]        pend_byte_q;
	logic              load;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && !pend_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_data_q <= '{out_byte: pend_byte_q, last: 1'b1};
			end else begin
				out_data_q  <= '{out_byte: q_head.b0, last: !q_head.two};
				pend_byte_q <= q_head.b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= pend_q || !q_empty;
			pend_q      <= !pend_q && !q_empty && q_head.two;
		end
	end

`ifndef SYNTHESIS
	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q && !out_data_q.last)
		else $error("second byte pending without its first byte on the output");
	a_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !out_stall |=> out_valid_q && out_data_q.last)
		else $error("second byte of a command not emitted as last");
`endif

endmodule

// ===== hw/rtl/delimited_field_quoter_unit.sv =====
// ----------------------------------------------------------------------------
// delimited_field_quoter_unit: delimited field quoter, top level
// Turns delimiter-separated text into space-separated quoted tokens.
// ----------------------------------------------------------------------------
// Usage: each input request carries one byte or an end-of-input mark and is
// accepted at a rising edge where in_valid is high and in_stall is low. Each
// request yields zero, one or two output requests on the out channel, the
// last of them flagged by last; a request that yields nothing (an end mark
// between tokens) simply updates nothing and leaves no trace on the output.
// The delimiter register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. It resets to a comma. The first output byte of a request
// passes through the command queue and then the output register before it
// is presented on out_valid. The output side emits one byte per cycle while
// out_stall is low, as set by the single-byte output register. A short
// command queue sits between the scanner front and the byte sequencer back,
// so the front keeps accepting requests while the back waits on a stalled
// receiver. When out_stall is high the output request holds; once the
// queue fills, in_stall rises. Reset clears the scan mode to between-tokens,
// empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module delimited_field_quoter_unit #(
	parameter int QueueDepth = dfq_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  dfq_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output dfq_pkg::out_req_t out_data
);

	// Front to queue: a command is pushed for every accepted request that
	// produces output bytes.
	logic          push;
	dfq_pkg::cmd_t push_cmd;
	// Queue to back: head command and fill status.
	logic          pop;
	dfq_pkg::cmd_t head;
	logic          q_full;
	logic          q_empty;

	dfq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	dfq_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// The back drains the queue one byte per cycle into the output register while out_stall is low.
	dfq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
